// ===== rtl/mips_integer_execute_unit_assert.svh =====
// assertion macros for the integer execute unit
`ifndef MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`define MIPS_INTEGER_EXECUTE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define MIU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MIU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`else
`define MIU_ASSERT(lbl, prop, msg)
`define MIU_ASSERT_IMPL(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/miu_pkg.sv =====
// shared types and codes for the integer execute unit
package miu_pkg;

  localparam logic [1:0] ACT_EXEC = 2'd0;
  localparam logic [1:0] ACT_LOAD = 2'd1;
  localparam logic [1:0] ACT_BOOT = 2'd2;
  localparam logic [1:0] ACT_RSVD = 2'd3;

  localparam logic [1:0] MREQ_NONE  = 2'd0;
  localparam logic [1:0] MREQ_LOAD  = 2'd1;
  localparam logic [1:0] MREQ_STORE = 2'd2;

  localparam logic [1:0] CFG_START_PC = 2'd0;
  localparam logic [1:0] CFG_GP_INIT  = 2'd1;
  localparam logic [1:0] CFG_SP_INIT  = 2'd2;

  localparam logic [2:0] LK_LB  = 3'd0;
  localparam logic [2:0] LK_LH  = 3'd1;
  localparam logic [2:0] LK_LW  = 3'd2;
  localparam logic [2:0] LK_LBU = 3'd3;
  localparam logic [2:0] LK_LHU = 3'd4;

  localparam logic [5:0] OP_SPECIAL = 6'h00;
  localparam logic [5:0] OP_REGIMM  = 6'h01;
  localparam logic [5:0] OP_J       = 6'h02;
  localparam logic [5:0] OP_JAL     = 6'h03;
  localparam logic [5:0] OP_BEQ     = 6'h04;
  localparam logic [5:0] OP_BNE     = 6'h05;
  localparam logic [5:0] OP_BLEZ    = 6'h06;
  localparam logic [5:0] OP_BGTZ    = 6'h07;
  localparam logic [5:0] OP_ADDI    = 6'h08;
  localparam logic [5:0] OP_ADDIU   = 6'h09;
  localparam logic [5:0] OP_SLTI    = 6'h0A;
  localparam logic [5:0] OP_SLTIU   = 6'h0B;
  localparam logic [5:0] OP_ANDI    = 6'h0C;
  localparam logic [5:0] OP_ORI     = 6'h0D;
  localparam logic [5:0] OP_XORI    = 6'h0E;
  localparam logic [5:0] OP_LUI     = 6'h0F;
  localparam logic [5:0] OP_LB      = 6'h20;
  localparam logic [5:0] OP_LH      = 6'h21;
  localparam logic [5:0] OP_LW      = 6'h23;
  localparam logic [5:0] OP_LBU     = 6'h24;
  localparam logic [5:0] OP_LHU     = 6'h25;
  localparam logic [5:0] OP_SB      = 6'h28;
  localparam logic [5:0] OP_SH      = 6'h29;
  localparam logic [5:0] OP_SW      = 6'h2B;

  localparam logic [5:0] FN_SLL     = 6'h00;
  localparam logic [5:0] FN_SRL     = 6'h02;
  localparam logic [5:0] FN_SRA     = 6'h03;
  localparam logic [5:0] FN_SLLV    = 6'h04;
  localparam logic [5:0] FN_SRLV    = 6'h06;
  localparam logic [5:0] FN_SRAV    = 6'h07;
  localparam logic [5:0] FN_JR      = 6'h08;
  localparam logic [5:0] FN_JALR    = 6'h09;
  localparam logic [5:0] FN_SYSCALL = 6'h0C;
  localparam logic [5:0] FN_MFHI    = 6'h10;
  localparam logic [5:0] FN_MTHI    = 6'h11;
  localparam logic [5:0] FN_MFLO    = 6'h12;
  localparam logic [5:0] FN_MTLO    = 6'h13;
  localparam logic [5:0] FN_MULT    = 6'h18;
  localparam logic [5:0] FN_MULTU   = 6'h19;
  localparam logic [5:0] FN_DIV     = 6'h1A;
  localparam logic [5:0] FN_DIVU    = 6'h1B;
  localparam logic [5:0] FN_ADD     = 6'h20;
  localparam logic [5:0] FN_ADDU    = 6'h21;
  localparam logic [5:0] FN_SUB     = 6'h22;
  localparam logic [5:0] FN_SUBU    = 6'h23;
  localparam logic [5:0] FN_AND     = 6'h24;
  localparam logic [5:0] FN_OR      = 6'h25;
  localparam logic [5:0] FN_XOR     = 6'h26;
  localparam logic [5:0] FN_NOR     = 6'h27;
  localparam logic [5:0] FN_SLT     = 6'h2A;
  localparam logic [5:0] FN_SLTU    = 6'h2B;

  localparam logic [5:0] RI_BLTZ    = 6'h00;

  typedef struct packed {
    logic [1:0]  mem_request;
    logic [31:0] mem_address;
    logic [31:0] mem_write_data;
    logic [3:0]  mem_byte_enable;
    logic        syscall_request;
    logic [31:0] syscall_code;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
  } res_t;

endpackage

// ===== rtl/miu_div.sv =====
// iterative restoring divider for unsigned 32-bit operands, one quotient bit a cycle
module miu_div import miu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] dividend_i,
  input  logic [31:0] divisor_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;

  assign trial = {rem_q, quo_q[31]} - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 5'd31;
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[32]) begin
        rem_d = {rem_q[30:0], quo_q[31]};
        quo_d = {quo_q[30:0], 1'b0};
      end else begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/mips_integer_execute_unit.sv =====
// MIPS-I integer execute unit: register file memory, control sequencer and result register
// Input channel (in_valid_i / in_stall_o) carries one request: execute an instruction,
// return data for a pending load, or boot. Output channel (out_valid_o / out_stall_i)
// carries one result per request: next pc, memory request, syscall and register write.
// The general registers sit in a 32-entry synchronous memory with two read ports,
// read at the accept edge; per-entry valid bits make unwritten registers read as zero.
// Steps per request, from accept to result visible in the output register:
//   ALU, branch, jump, load, store, load return: execute, then output
//   mult/multu: execute, mul (product registered before hi/lo update), output
//   div/divu: execute, div (one-bit-a-cycle divider), output; no div for a zero divisor
//   boot: execute, boot1, boot2, output; single write port takes r28, r29, r31 in turn
// One request is in flight at a time; in_stall_o is high from accept until the result
// moves into the output register, and the next request is taken once the sequencer is
// back in idle. A finished result waits in the output register while the receiver stalls,
// and the next request is accepted meanwhile.
// Configuration writes (cfg_we_i) are taken in any cycle and used at boot.
// Reset clears registers, hi, lo, pc and the pending load; no clearing pass is needed.
`include "mips_integer_execute_unit_assert.svh"
module mips_integer_execute_unit import miu_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] instr_word_i,
  input  logic [31:0] load_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] next_pc_o,
  output logic [1:0]  mem_request_o,
  output logic [31:0] mem_address_o,
  output logic [31:0] mem_write_data_o,
  output logic [3:0]  mem_byte_enable_o,
  output logic        syscall_request_o,
  output logic [31:0] syscall_code_o,
  output logic        reg_written_o,
  output logic [4:0]  reg_index_o,
  output logic [31:0] reg_value_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_BOOT1 = 3'd4;
  localparam logic [2:0] S_BOOT2 = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam logic [4:0] R_V0 = 5'd2;
  localparam logic [4:0] R_GP = 5'd28;
  localparam logic [4:0] R_SP = 5'd29;
  localparam logic [4:0] R_RA = 5'd31;

  logic [2:0]  state_q, state_d;
  logic [31:0] start_pc_q, gp_init_q, sp_init_q;
  logic [1:0]  act_q;
  logic [31:0] iw_q, ld_q;
  logic [31:0] pc_q, pc_d;
  logic [31:0] hi_q, hi_d, lo_q, lo_d;
  logic        ld_pend_q, ld_pend_d;
  logic [4:0]  ld_dest_q, ld_dest_d;
  logic [2:0]  ld_kind_q, ld_kind_d;
  logic [1:0]  ld_off_q, ld_off_d;
  logic [63:0] prod_q;
  logic        div_sa_q, div_sr_q;
  res_t        res_q, res_d, out_q;
  logic [31:0] out_pc_q;
  logic        out_valid_q;

  // register file memory
  logic [31:0] rf_mem [32];
  logic [31:0] rf_valid_q;
  logic [31:0] rda_q, rdb_q;
  logic        rva_q, rvb_q;
  logic        rf_we;
  logic [4:0]  rf_waddr;
  logic [31:0] rf_wdata;
  logic [4:0]  rd_addr_a;

  logic in_acc;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // syscall reads v0 through port a in place of rs
  assign rd_addr_a = (instr_word_i[31:26] == OP_SPECIAL && instr_word_i[5:0] == FN_SYSCALL)
                     ? R_V0 : instr_word_i[25:21];

  always_ff @(posedge clk_i) begin
    if (rf_we) begin
      rf_mem[rf_waddr] <= rf_wdata;
    end
    if (in_acc) begin
      rda_q <= rf_mem[rd_addr_a];
      rdb_q <= rf_mem[instr_word_i[20:16]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rf_valid_q <= '0;
      rva_q      <= 1'b0;
      rvb_q      <= 1'b0;
    end else begin
      if (rf_we) begin
        rf_valid_q[rf_waddr] <= 1'b1;
      end
      if (in_acc) begin
        rva_q <= rf_valid_q[rd_addr_a];
        rvb_q <= rf_valid_q[instr_word_i[20:16]];
      end
    end
  end

  // decode
  logic [5:0]  op, fn;
  logic [4:0]  rt, rd, sh;
  logic [31:0] a, b, imm, zimm, pc4, btarget, ea;
  logic [1:0]  off;
  logic [4:0]  a_sh;
  logic        neg;

  assign op      = iw_q[31:26];
  assign rt      = iw_q[20:16];
  assign rd      = iw_q[15:11];
  assign sh      = iw_q[10:6];
  assign fn      = iw_q[5:0];
  assign a       = rva_q ? rda_q : '0;
  assign b       = rvb_q ? rdb_q : '0;
  assign imm     = {{16{iw_q[15]}}, iw_q[15:0]};
  assign zimm    = {16'h0000, iw_q[15:0]};
  assign pc4     = pc_q + 32'd4;
  assign btarget = pc4 + {imm[29:0], 2'b00};
  assign ea      = a + imm;
  assign off     = ea[1:0];
  assign a_sh    = a[4:0];
  assign neg     = a[31];

  // multiplier operands, sign-extended to 33 bits for mult
  logic        mul_sg;
  logic [65:0] mul_full;
  assign mul_sg   = (fn == FN_MULT);
  assign mul_full = 66'($signed({mul_sg & a[31], a}) * $signed({mul_sg & b[31], b}));

  // divider
  logic        div_start, div_done;
  logic        div_sg;
  logic [31:0] div_ua, div_ub, div_q, div_r;
  assign div_sg = (fn == FN_DIV);
  assign div_ua = (div_sg && a[31]) ? (32'd0 - a) : a;
  assign div_ub = (div_sg && b[31]) ? (32'd0 - b) : b;

  miu_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_ua),
    .divisor_i  (div_ub),
    .done_o     (div_done),
    .quo_o      (div_q),
    .rem_o      (div_r)
  );

  // load return extraction
  logic [31:0] ld_sh;
  logic [7:0]  ld_by;
  logic [15:0] ld_hw;
  logic [31:0] ld_val;
  assign ld_sh = ld_q >> {ld_off_q, 3'b000};
  assign ld_by = ld_sh[7:0];
  assign ld_hw = ld_off_q[1] ? ld_q[31:16] : ld_q[15:0];
  always_comb begin
    case (ld_kind_q)
      LK_LB:   ld_val = {{24{ld_by[7]}}, ld_by};
      LK_LH:   ld_val = {{16{ld_hw[15]}}, ld_hw};
      LK_LBU:  ld_val = {24'h000000, ld_by};
      LK_LHU:  ld_val = {16'h0000, ld_hw};
      default: ld_val = ld_q;
    endcase
  end

  // execute step
  logic        wr_en;
  logic [4:0]  wr_idx;
  logic [31:0] wr_val;
  logic        go_mul, go_div, go_boot;

  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = rd;
    wr_val    = '0;
    pc_d      = pc4;
    hi_d      = hi_q;
    lo_d      = lo_q;
    ld_pend_d = ld_pend_q;
    ld_dest_d = ld_dest_q;
    ld_kind_d = ld_kind_q;
    ld_off_d  = ld_off_q;
    go_mul    = 1'b0;
    go_div    = 1'b0;
    go_boot   = 1'b0;
    res_d     = '0;
    case (act_q)
      ACT_EXEC: begin
        case (op)
          OP_SPECIAL: begin
            case (fn)
              FN_SLL:  begin wr_en = 1'b1; wr_val = b << sh; end
              FN_SRL:  begin wr_en = 1'b1; wr_val = b >> sh; end
              FN_SRA:  begin wr_en = 1'b1; wr_val = 32'($signed(b) >>> sh); end
              FN_SLLV: begin wr_en = 1'b1; wr_val = b << a_sh; end
              FN_SRLV: begin wr_en = 1'b1; wr_val = b >> a_sh; end
              FN_SRAV: begin wr_en = 1'b1; wr_val = 32'($signed(b) >>> a_sh); end
              FN_JR:   pc_d = a;
              FN_JALR: begin
                pc_d   = a;
                wr_en  = 1'b1;
                wr_idx = (rd == 5'd0) ? R_RA : rd;
                wr_val = pc4;
              end
              FN_SYSCALL: begin
                res_d.syscall_request = 1'b1;
                res_d.syscall_code    = a;
              end
              FN_MFHI: begin wr_en = 1'b1; wr_val = hi_q; end
              FN_MTHI: hi_d = a;
              FN_MFLO: begin wr_en = 1'b1; wr_val = lo_q; end
              FN_MTLO: lo_d = a;
              FN_MULT, FN_MULTU: go_mul = 1'b1;
              FN_DIV, FN_DIVU:   go_div = (b != 32'd0);
              FN_ADD, FN_ADDU:   begin wr_en = 1'b1; wr_val = a + b; end
              FN_SUB, FN_SUBU:   begin wr_en = 1'b1; wr_val = a - b; end
              FN_AND:  begin wr_en = 1'b1; wr_val = a & b; end
              FN_OR:   begin wr_en = 1'b1; wr_val = a | b; end
              FN_XOR:  begin wr_en = 1'b1; wr_val = a ^ b; end
              FN_NOR:  begin wr_en = 1'b1; wr_val = ~(a | b); end
              FN_SLT:  begin wr_en = 1'b1; wr_val = {31'd0, $signed(a) < $signed(b)}; end
              FN_SLTU: begin wr_en = 1'b1; wr_val = {31'd0, a < b}; end
              default: ;
            endcase
          end
          OP_REGIMM: begin
            // bltz, bgez and their linking forms
            if (rt[3:1] == RI_BLTZ[3:1]) begin
              if (rt[4]) begin
                wr_en  = 1'b1;
                wr_idx = R_RA;
                wr_val = pc4;
              end
              if (rt[0] ? !neg : neg) pc_d = btarget;
            end
          end
          OP_J, OP_JAL: begin
            pc_d = {pc4[31:28], iw_q[25:0], 2'b00};
            if (op == OP_JAL) begin
              wr_en  = 1'b1;
              wr_idx = R_RA;
              wr_val = pc4;
            end
          end
          OP_BEQ:  if (a == b) pc_d = btarget;
          OP_BNE:  if (a != b) pc_d = btarget;
          OP_BLEZ: if (a == 32'd0 || neg) pc_d = btarget;
          OP_BGTZ: if (a != 32'd0 && !neg) pc_d = btarget;
          OP_ADDI, OP_ADDIU: begin wr_en = 1'b1; wr_idx = rt; wr_val = a + imm; end
          OP_SLTI: begin
            wr_en = 1'b1; wr_idx = rt; wr_val = {31'd0, $signed(a) < $signed(imm)};
          end
          OP_SLTIU: begin wr_en = 1'b1; wr_idx = rt; wr_val = {31'd0, a < imm}; end
          OP_ANDI: begin wr_en = 1'b1; wr_idx = rt; wr_val = a & zimm; end
          OP_ORI:  begin wr_en = 1'b1; wr_idx = rt; wr_val = a | zimm; end
          OP_XORI: begin wr_en = 1'b1; wr_idx = rt; wr_val = a ^ zimm; end
          OP_LUI:  begin wr_en = 1'b1; wr_idx = rt; wr_val = {iw_q[15:0], 16'h0000}; end
          OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU: begin
            case (op)
              OP_LB:   ld_kind_d = LK_LB;
              OP_LH:   ld_kind_d = LK_LH;
              OP_LW:   ld_kind_d = LK_LW;
              OP_LBU:  ld_kind_d = LK_LBU;
              default: ld_kind_d = LK_LHU;
            endcase
            res_d.mem_request = MREQ_LOAD;
            res_d.mem_address = ea;
            if (op == OP_LW) res_d.mem_byte_enable = 4'hF;
            else if (op == OP_LB || op == OP_LBU) res_d.mem_byte_enable = 4'b0001 << off;
            else res_d.mem_byte_enable = 4'b0011 << {off[1], 1'b0};
            ld_pend_d = 1'b1;
            ld_dest_d = rt;
            ld_off_d  = off;
          end
          OP_SB: begin
            res_d.mem_request     = MREQ_STORE;
            res_d.mem_address     = ea;
            res_d.mem_write_data  = {24'h000000, b[7:0]} << {off, 3'b000};
            res_d.mem_byte_enable = 4'b0001 << off;
          end
          OP_SH: begin
            res_d.mem_request     = MREQ_STORE;
            res_d.mem_address     = ea;
            res_d.mem_write_data  = {16'h0000, b[15:0]} << {off[1], 4'b0000};
            res_d.mem_byte_enable = 4'b0011 << {off[1], 1'b0};
          end
          OP_SW: begin
            res_d.mem_request     = MREQ_STORE;
            res_d.mem_address     = ea;
            res_d.mem_write_data  = b;
            res_d.mem_byte_enable = 4'hF;
          end
          default: ;
        endcase
      end
      ACT_LOAD: begin
        pc_d = pc_q;
        if (ld_pend_q) begin
          ld_pend_d = 1'b0;
          wr_en     = 1'b1;
          wr_idx    = ld_dest_q;
          wr_val    = ld_val;
        end
      end
      ACT_BOOT: begin
        pc_d      = start_pc_q;
        ld_pend_d = 1'b0;
        go_boot   = 1'b1;
      end
      default: pc_d = pc_q;
    endcase
    // r0 is never written
    if (wr_en && wr_idx != 5'd0) begin
      res_d.reg_written = 1'b1;
      res_d.reg_index   = wr_idx;
      res_d.reg_value   = wr_val;
    end
  end

  assign div_start = (state_q == S_EXEC) && go_div;

  // register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_waddr = '0;
    rf_wdata = '0;
    case (state_q)
      S_EXEC: begin
        if (go_boot) begin
          rf_we = 1'b1; rf_waddr = R_GP; rf_wdata = gp_init_q;
        end else begin
          rf_we = res_d.reg_written; rf_waddr = res_d.reg_index; rf_wdata = res_d.reg_value;
        end
      end
      S_BOOT1: begin rf_we = 1'b1; rf_waddr = R_SP; rf_wdata = sp_init_q; end
      S_BOOT2: begin rf_we = 1'b1; rf_waddr = R_RA; rf_wdata = start_pc_q; end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_acc) state_d = S_EXEC;
      S_EXEC: begin
        if (go_boot)     state_d = S_BOOT1;
        else if (go_mul) state_d = S_MUL;
        else if (go_div) state_d = S_DIV;
        else             state_d = S_OUT;
      end
      S_MUL:   state_d = S_OUT;
      S_DIV:   if (div_done) state_d = S_OUT;
      S_BOOT1: state_d = S_BOOT2;
      S_BOOT2: state_d = S_OUT;
      S_OUT:   if (!out_valid_q || !out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      start_pc_q  <= '0;
      gp_init_q   <= '0;
      sp_init_q   <= '0;
      pc_q        <= '0;
      hi_q        <= '0;
      lo_q        <= '0;
      ld_pend_q   <= 1'b0;
      ld_dest_q   <= '0;
      ld_kind_q   <= '0;
      ld_off_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_START_PC: start_pc_q <= cfg_data_i;
          CFG_GP_INIT:  gp_init_q  <= cfg_data_i;
          CFG_SP_INIT:  sp_init_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == S_EXEC) begin
        pc_q      <= pc_d;
        hi_q      <= hi_d;
        lo_q      <= lo_d;
        ld_pend_q <= ld_pend_d;
        ld_dest_q <= ld_dest_d;
        ld_kind_q <= ld_kind_d;
        ld_off_q  <= ld_off_d;
      end
      if (state_q == S_MUL) begin
        hi_q <= prod_q[63:32];
        lo_q <= prod_q[31:0];
      end
      if (state_q == S_DIV && div_done) begin
        lo_q <= div_sa_q ? (32'd0 - div_q) : div_q;
        hi_q <= div_sr_q ? (32'd0 - div_r) : div_r;
      end
      if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q <= action_i;
      iw_q  <= instr_word_i;
      ld_q  <= load_data_i;
    end
    if (state_q == S_EXEC) begin
      res_q    <= res_d;
      prod_q   <= mul_full[63:0];
      div_sa_q <= div_sg && (a[31] != b[31]);
      div_sr_q <= div_sg && a[31];
    end
    if (state_q == S_OUT && (!out_valid_q || !out_stall_i)) begin
      out_q    <= res_q;
      out_pc_q <= pc_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign next_pc_o         = out_pc_q;
  assign mem_request_o     = out_q.mem_request;
  assign mem_address_o     = out_q.mem_address;
  assign mem_write_data_o  = out_q.mem_write_data;
  assign mem_byte_enable_o = out_q.mem_byte_enable;
  assign syscall_request_o = out_q.syscall_request;
  assign syscall_code_o    = out_q.syscall_code;
  assign reg_written_o     = out_q.reg_written;
  assign reg_index_o       = out_q.reg_index;
  assign reg_value_o       = out_q.reg_value;

  `MIU_ASSERT(a_acc_exec, (in_valid_i && !in_stall_o) |=> (state_q == S_EXEC),
              "accepted request did not enter execute")
  `MIU_ASSERT_IMPL(a_no_r0_write, rf_we, rf_waddr != 5'd0, "write to register zero")
  `MIU_ASSERT_IMPL(a_out_from_seq, $rose(out_valid_q), $past(state_q) == S_OUT,
                   "result appeared outside the output step")
  `MIU_ASSERT_IMPL(a_div_done_wait, div_done, state_q == S_DIV,
                   "divider finished while not awaited")

endmodule
